// ===== hw/rtl/mcot_pkg.sv =====
package mcot_pkg;

   localparam int NUM_TIMERS_DEF  = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int INDEX_W     = 4;
   localparam int PERIOD_W    = 16;
   localparam int MASK_W      = 16;
   localparam int RATIO_W     = 8;
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd1;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_START      = 2'd1,
      CMD_SUSPEND    = 2'd2,
      CMD_SET_PERIOD = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_WR,
      ST_SWEEP,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_wr;
      logic sweep_rd;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_start;
      logic presc_hit;
      logic sweep_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/mcot_ctrl.sv =====
module mcot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mcot_pkg::dp_stat_type stat,
   output mcot_pkg::ctl_cmd_type cmd
);

   mcot_pkg::state_type state_ff;
   mcot_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcot_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcot_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (stat.is_tick) begin
                  state_in = stat.presc_hit ? mcot_pkg::ST_SWEEP : mcot_pkg::ST_EMIT;
               end else if (stat.is_start) begin
                  state_in = mcot_pkg::ST_START_WR;
               end
            end
         end
         mcot_pkg::ST_START_WR: state_in = mcot_pkg::ST_IDLE;
         mcot_pkg::ST_SWEEP: begin
            if (stat.sweep_last) begin
               state_in = mcot_pkg::ST_DRAIN;
            end
         end
         mcot_pkg::ST_DRAIN: state_in = mcot_pkg::ST_EMIT;
         mcot_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               state_in = mcot_pkg::ST_IDLE;
            end
         end
         default: state_in = mcot_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == mcot_pkg::ST_IDLE);
      cmd.load     = (state_ff == mcot_pkg::ST_IDLE) && req_tvalid;
      cmd.start_wr = (state_ff == mcot_pkg::ST_START_WR);
      cmd.sweep_rd = (state_ff == mcot_pkg::ST_SWEEP);
      cmd.emit     = (state_ff == mcot_pkg::ST_EMIT) && stat.out_free;
   end

endmodule

// ===== hw/rtl/mcot_dp.sv =====
module mcot_dp #(
   parameter int NUM_TIMERS  = mcot_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = mcot_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mcot_pkg::RATIO_W-1:0]        csr_wr_data,
   input  logic [mcot_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [mcot_pkg::REQ_USER_W-1:0]     req_tuser,
   input  mcot_pkg::ctl_cmd_type               cmd,
   output mcot_pkg::dp_stat_type               stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [mcot_pkg::MASK_W-1:0]         rsp_tdata
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   mcot_pkg::cmd_type                req_cmd;
   logic [mcot_pkg::INDEX_W-1:0]     req_idx;
   logic [mcot_pkg::PERIOD_W-1:0]    req_period;
   logic [IDX_W-1:0]                 req_addr;
   logic [COUNT_WIDTH-1:0]           req_val;
   logic                             idx_ok;
   logic                             period_we;

   logic [mcot_pkg::RATIO_W-1:0]     ratio_ff;
   logic [mcot_pkg::RATIO_W-1:0]     presc_cnt_ff;

   logic [NUM_TIMERS-1:0]            active_ff;
   logic [NUM_TIMERS-1:0]            active_in;
   logic [NUM_TIMERS-1:0]            period_set_ff;

   logic [COUNT_WIDTH-1:0]           period_mem [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]           period_rd_ff;
   logic                             period_rd_set_ff;
   logic [COUNT_WIDTH-1:0]           rem_mem [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]           rem_rd_ff;

   logic [IDX_W-1:0]                 item_addr_ff;
   logic [IDX_W-1:0]                 sweep_cnt_ff;
   logic                             proc_vld_ff;
   logic [IDX_W-1:0]                 proc_idx_ff;
   logic                             proc_active;
   logic                             expire;

   logic                             rem_we;
   logic [IDX_W-1:0]                 rem_waddr;
   logic [COUNT_WIDTH-1:0]           rem_wdata;

   logic [mcot_pkg::MASK_W-1:0]      mask_ff;
   logic                             rsp_valid_ff;
   logic [mcot_pkg::MASK_W-1:0]      rsp_data_ff;

   always_comb begin
      req_cmd    = mcot_pkg::cmd_type'(req_tuser);
      req_idx    = req_tdata[mcot_pkg::INDEX_W-1:0];
      req_period = req_tdata[mcot_pkg::INDEX_W +: mcot_pkg::PERIOD_W];
      req_addr   = IDX_W'(req_idx);
      req_val    = COUNT_WIDTH'(req_period);
      idx_ok     = (32'(req_idx) < 32'(NUM_TIMERS));
      period_we  = cmd.load && (req_cmd == mcot_pkg::CMD_SET_PERIOD) && idx_ok &&
                   (req_val != '0);
   end

   always_comb begin
      proc_active = proc_vld_ff && active_ff[proc_idx_ff];
      expire      = proc_active && (rem_rd_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= mcot_pkg::RATIO_RESET;
      end else if (csr_wr_en) begin
         ratio_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_cnt_ff <= '0;
      end else if (cmd.load && (req_cmd == mcot_pkg::CMD_TICK)) begin
         if (presc_cnt_ff == ratio_ff) begin
            presc_cnt_ff <= '0;
         end else begin
            presc_cnt_ff <= presc_cnt_ff + (mcot_pkg::RATIO_W)'(1);
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.load && (req_cmd == mcot_pkg::CMD_SUSPEND) && idx_ok) begin
         active_in[req_addr] = 1'b0;
      end
      if (cmd.start_wr) begin
         active_in[item_addr_ff] = 1'b1;
      end
      if (expire) begin
         active_in[proc_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         period_set_ff <= '0;
      end else begin
         active_ff <= active_in;
         if (period_we) begin
            period_set_ff[req_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (period_we) begin
         period_mem[req_addr] <= req_val;
      end
      period_rd_ff     <= period_mem[req_addr];
      period_rd_set_ff <= period_set_ff[req_addr];
   end

   always_comb begin
      rem_we    = cmd.start_wr || (proc_active && (rem_rd_ff != '0));
      rem_waddr = cmd.start_wr ? item_addr_ff : proc_idx_ff;
      if (cmd.start_wr) begin
         rem_wdata = period_rd_set_ff ? period_rd_ff : '0;
      end else begin
         rem_wdata = rem_rd_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      rem_rd_ff <= rem_mem[sweep_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_addr_ff <= req_addr;
      end
      proc_idx_ff <= sweep_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         proc_vld_ff  <= 1'b0;
         mask_ff      <= '0;
      end else begin
         proc_vld_ff <= cmd.sweep_rd;
         if (cmd.load) begin
            sweep_cnt_ff <= '0;
            mask_ff      <= '0;
         end else begin
            if (cmd.sweep_rd) begin
               sweep_cnt_ff <= sweep_cnt_ff + IDX_W'(1);
            end
            if (expire && (32'(proc_idx_ff) < mcot_pkg::MASK_W)) begin
               mask_ff[4'(proc_idx_ff)] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= mask_ff;
      end
   end

   always_comb begin
      stat.is_tick    = (req_cmd == mcot_pkg::CMD_TICK);
      stat.is_start   = (req_cmd == mcot_pkg::CMD_START) && idx_ok;
      stat.presc_hit  = (presc_cnt_ff == ratio_ff);
      stat.sweep_last = (sweep_cnt_ff == IDX_W'(NUM_TIMERS - 1));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      rsp_tvalid      = rsp_valid_ff;
      rsp_tdata       = rsp_data_ff;
   end

endmodule

// ===== hw/rtl/multi_channel_oneshot_timer_bank_top.sv =====
// Bank of one-shot down-counting timers driven by a command stream.
// Each request transfer carries one command in req_tuser: tick, start,
// suspend or set-period, with the timer index and period in req_tdata.
// Only a tick produces a response transfer, whose rsp_tdata holds the mask
// of timers that expired on it (zero when the prescaler swallows the tick).
// The prescale ratio is written through csr_wr_en and csr_wr_data.
// Suspend and set-period complete as the request is taken, while start
// passes through a write state, since the period is read from its memory
// and then copied into the count memory. A tick that is not acted on
// goes straight to the emit state. An acted tick walks the count memory
// one timer per cycle, through sweep and drain, before the next request is taken.
// Reset clears the prescaler, marks all timers inactive and all periods
// zero, and sets the ratio to one; no clearing pass is needed.
// A finished response waits in an output register; a stalled receiver
// holds a tick in its final state until that register frees up, while
// other commands are still accepted as long as no tick is pending.
module multi_channel_oneshot_timer_bank_top #(
   parameter int NUM_TIMERS  = mcot_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = mcot_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mcot_pkg::RATIO_W-1:0]     csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: timer_index[3:0], period_value[19:4], zero pad.
   input  logic [mcot_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0: cmd[1:0].
   input  logic [mcot_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: expired_mask[15:0].
   output logic [mcot_pkg::MASK_W-1:0]      rsp_tdata
);

   mcot_pkg::ctl_cmd_type ctl_cmd;
   mcot_pkg::dp_stat_type dp_stat;

   mcot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctl_cmd)
   );

   mcot_dp #(
      .NUM_TIMERS  (NUM_TIMERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (ctl_cmd),
      .stat        (dp_stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== hw/rtl/mcot_checker.sv =====
module mcot_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [mcot_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mcot_pkg::MASK_W-1:0]      rsp_tdata
);

   logic tick_xfer;
   logic other_xfer;

   assign tick_xfer  = req_tvalid && req_tready && (req_tuser == mcot_pkg::CMD_TICK);
   assign other_xfer = req_tvalid && req_tready && (req_tuser != mcot_pkg::CMD_TICK);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> !req_tready)
      else $error("request taken while a tick is in progress");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      other_xfer && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response produced by a command other than tick");

endmodule

bind multi_channel_oneshot_timer_bank_top mcot_checker u_mcot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/multi_channel_oneshot_timer_bank_top_test.sv =====
`timescale 1ns / 100ps

class timer_bank_scoreboard;
   logic [mcot_pkg::RATIO_W-1:0]  ratio;
   logic [mcot_pkg::RATIO_W-1:0]  presc_count;
   bit                            timer_on [mcot_pkg::NUM_TIMERS_DEF];
   logic [mcot_pkg::PERIOD_W-1:0] timer_period [mcot_pkg::NUM_TIMERS_DEF];
   logic [mcot_pkg::PERIOD_W-1:0] timer_left [mcot_pkg::NUM_TIMERS_DEF];
   logic [mcot_pkg::MASK_W-1:0]   expected_masks [$];
   int                            errors;
   int                            acted_ticks;
   int                            expirations;

   function new();
      int t;
      ratio = mcot_pkg::RATIO_RESET;
      presc_count = '0;
      errors = 0;
      acted_ticks = 0;
      expirations = 0;
      for (t = 0; t < mcot_pkg::NUM_TIMERS_DEF; t++) begin
         timer_on[t] = 1'b0;
         timer_period[t] = '0;
         timer_left[t] = '0;
      end
   endfunction

   function logic [mcot_pkg::MASK_W-1:0] apply_tick();
      logic [mcot_pkg::MASK_W-1:0] mask;
      int t;
      mask = '0;
      if (presc_count != ratio) begin
         presc_count++;
         return mask;
      end
      presc_count = '0;
      acted_ticks++;
      for (t = 0; t < mcot_pkg::NUM_TIMERS_DEF; t++) begin
         if (timer_on[t]) begin
            if (timer_left[t] == '0) begin
               timer_on[t] = 1'b0;
               mask[t] = 1'b1;
               expirations++;
            end else begin
               timer_left[t]--;
            end
         end
      end
      return mask;
   endfunction

   function void note_command(mcot_pkg::cmd_type cmd, logic [mcot_pkg::INDEX_W-1:0] idx,
                              logic [mcot_pkg::PERIOD_W-1:0] val);
      if (cmd == mcot_pkg::CMD_TICK) begin
         expected_masks.push_back(apply_tick());
      end else if (int'(idx) < mcot_pkg::NUM_TIMERS_DEF) begin
         case (cmd)
            mcot_pkg::CMD_START: begin
               timer_left[idx] = timer_period[idx];
               timer_on[idx] = 1'b1;
            end
            mcot_pkg::CMD_SUSPEND: begin
               timer_on[idx] = 1'b0;
            end
            default: begin
               if (val != '0) timer_period[idx] = val;
            end
         endcase
      end
   endfunction

   function void check_mask(logic [mcot_pkg::MASK_W-1:0] got);
      logic [mcot_pkg::MASK_W-1:0] want;
      if (expected_masks.size() == 0) begin
         errors++;
         $display("%0t: response with no tick pending, expected none, actual %h", $time, got);
      end else begin
         want = expected_masks.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: expired_mask mismatch, expected %h, actual %h", $time, want, got);
         end
      end
   endfunction
endclass

module multi_channel_oneshot_timer_bank_top_test;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = mcot_pkg::NUM_TIMERS_DEF + 8;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [mcot_pkg::RATIO_W-1:0]    csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [mcot_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [mcot_pkg::REQ_USER_W-1:0] req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [mcot_pkg::MASK_W-1:0]     rsp_tdata;

   timer_bank_scoreboard bank_model;
   int cycle_count    = 0;
   int burst_left     = 0;
   int stall_mode     = 0;
   int commands_sent  = 0;
   int ratio_writes   = 0;

   multi_channel_oneshot_timer_bank_top #(
      .NUM_TIMERS(mcot_pkg::NUM_TIMERS_DEF),
      .COUNT_WIDTH(mcot_pkg::COUNT_WIDTH_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multi_channel_oneshot_timer_bank_top_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cycle_count % 6 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) bank_model.check_mask(rsp_tdata);
   end

   task send_command(input mcot_pkg::cmd_type cmd,
                     input logic [mcot_pkg::INDEX_W-1:0] idx,
                     input logic [mcot_pkg::PERIOD_W-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bank_model.note_command(cmd, idx, val);
      commands_sent++;
   endtask

   task pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // The sender holds off until every tick has answered, then lets the
   // block finish any start still in flight.
   task drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bank_model.expected_masks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_ratio(input logic [mcot_pkg::RATIO_W-1:0] value);
      drain_and_settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      bank_model.ratio = value;
      ratio_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task run_directed();
      send_command(mcot_pkg::CMD_TICK, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_TICK, 4'd15, 16'hFFFF);
      send_command(mcot_pkg::CMD_SET_PERIOD, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_START, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_TICK, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_TICK, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_SET_PERIOD, 4'd15, 16'hFFFF);
      send_command(mcot_pkg::CMD_SET_PERIOD, 4'd3, 16'h0002);
      send_command(mcot_pkg::CMD_SET_PERIOD, 4'd3, 16'h0000);
      send_command(mcot_pkg::CMD_START, 4'd3, 16'h0000);
      send_command(mcot_pkg::CMD_START, 4'd15, 16'h0000);
      send_command(mcot_pkg::CMD_TICK, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_TICK, 4'd0, 16'h0000);
      send_command(mcot_pkg::CMD_START, 4'd3, 16'hFFFF);
      send_command(mcot_pkg::CMD_SUSPEND, 4'd15, 16'h0000);
      send_command(mcot_pkg::CMD_SUSPEND, 4'd7, 16'h0000);
      send_command(mcot_pkg::CMD_SET_PERIOD, 4'd5, 16'h0001);
      send_command(mcot_pkg::CMD_START, 4'd5, 16'h0000);
      send_command(mcot_pkg::CMD_START, 4'd10, 16'h0000);
      for (int n = 0; n < 6; n++) send_command(mcot_pkg::CMD_TICK, 4'hF, 16'h0000);
   endtask

   task random_phase(input int count, input int tick_pct);
      mcot_pkg::cmd_type              cmd;
      logic [mcot_pkg::INDEX_W-1:0]   idx;
      logic [mcot_pkg::PERIOD_W-1:0]  val;
      int                             roll;
      int                             n;
      for (n = 0; n < count; n++) begin
         pace_sender();
         roll = $urandom_range(0, 99);
         if (roll < tick_pct) begin
            cmd = mcot_pkg::CMD_TICK;
         end else begin
            roll = $urandom_range(0, 9);
            cmd = (roll < 4) ? mcot_pkg::CMD_START :
                  (roll < 6) ? mcot_pkg::CMD_SUSPEND : mcot_pkg::CMD_SET_PERIOD;
         end
         idx = mcot_pkg::INDEX_W'($urandom_range(0, 15));
         roll = $urandom_range(0, 19);
         if (roll < 13) val = 16'($urandom_range(1, 8));
         else if (roll < 16) val = '0;
         else val = 16'($urandom_range(0, 65535));
         send_command(cmd, idx, val);
      end
   endtask

   initial begin
      bank_model = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      write_ratio(8'd0);
      random_phase(400, 50);
      write_ratio(8'd255);
      random_phase(300, 85);
      write_ratio(8'd2);
      random_phase(200, 50);
      write_ratio(8'($urandom_range(3, 12)));
      random_phase(200, 60);
      write_ratio(8'd0);
      random_phase(200, 45);
      drain_and_settle();
      $display("Sent %0d commands across %0d prescale settings.", commands_sent, ratio_writes);
      $display("Saw %0d acted ticks and %0d timer expirations.",
               bank_model.acted_ticks, bank_model.expirations);
      if (bank_model.errors == 0 && bank_model.expected_masks.size() == 0) begin
         $display("multi_channel_oneshot_timer_bank_top_test: PASS");
      end else begin
         $display("multi_channel_oneshot_timer_bank_top_test: FAIL");
      end
      $finish;
   end

endmodule
